/* design/mlr_pkg.sv */
// Package for the multichannel linear resampler.
// Holds word types, controller command types, register indexes and constants.
// No dependencies.
package mlr_pkg;

  localparam int unsigned NumChannels = 8;
  localparam int unsigned NchMax      = 8;
  localparam int unsigned FrameLen    = 64;
  localparam int unsigned FramePosW   = (FrameLen > 1) ? $clog2(FrameLen) : 1;

  localparam int unsigned SampleW = 32;
  localparam int unsigned GainW   = 32;
  localparam int unsigned AudioW  = 24;
  localparam int unsigned PhaseW  = 17;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned CountW  = 6;

  localparam logic [PhaseW-1:0] PhaseOne  = 17'h10000;
  localparam logic [PhaseW-1:0] MinInc    = 17'd2048;
  localparam logic [CountW-1:0] MaxResults = 6'd32;

  localparam logic [PhaseW-1:0]   PhaseIncReset = 17'h10000;
  localparam logic [CfgDataW-1:0] GainPairReset = 64'h0100_0000_0100_0000;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PHASE_INC = 3'd0,
    CFG_GAIN_A    = 3'd1,
    CFG_GAIN_B    = 3'd2,
    CFG_GAIN_C    = 3'd3,
    CFG_GAIN_D    = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic signed [SampleW-1:0] sample_ch1;
    logic signed [SampleW-1:0] sample_ch2;
    logic signed [SampleW-1:0] sample_ch3;
    logic signed [SampleW-1:0] sample_ch4;
    logic signed [SampleW-1:0] sample_ch5;
    logic signed [SampleW-1:0] sample_ch6;
    logic signed [SampleW-1:0] sample_ch7;
    logic signed [SampleW-1:0] sample_ch8;
  } in_word_t;

  typedef struct packed {
    logic signed [AudioW-1:0] audio_ch1;
    logic signed [AudioW-1:0] audio_ch2;
    logic signed [AudioW-1:0] audio_ch3;
    logic signed [AudioW-1:0] audio_ch4;
    logic signed [AudioW-1:0] audio_ch5;
    logic signed [AudioW-1:0] audio_ch6;
    logic signed [AudioW-1:0] audio_ch7;
    logic signed [AudioW-1:0] audio_ch8;
    logic                     frame_end;
  } out_word_t;

  // Controller to datapath
  typedef struct packed {
    logic              load_prod;
    logic              load_cur;
    logic              commit;
    logic [PhaseW-1:0] phase;
  } dp_cmd_t;

  // Top level to controller
  typedef struct packed {
    logic in_valid;
    logic out_free;
  } ctrl_stat_t;

endpackage

/* design/mlr_ctrl.sv */
// Controller for the multichannel linear resampler.
// Sequences scaling, interpolation and commit; owns phase and frame counters.
// Depends on mlr_pkg.
module mlr_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  mlr_pkg::ctrl_stat_t         stat_i,
  input  logic [mlr_pkg::PhaseW-1:0]  phase_inc_i,
  output mlr_pkg::dp_cmd_t            cmd_o,
  output logic                        idle_o,
  output logic                        emit_o,
  output logic                        frame_end_o
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_MUL    = 4'b0010,
    ST_EMIT   = 4'b0100,
    ST_COMMIT = 4'b1000
  } state_e;

  state_e                          state_q, state_d;
  logic [mlr_pkg::PhaseW-1:0]      phase_q, phase_d;
  logic [mlr_pkg::FramePosW-1:0]   frame_q, frame_d;
  logic [mlr_pkg::CountW-1:0]      count_q, count_d;
  logic                            have_prev_q, have_prev_d;
  logic [mlr_pkg::PhaseW-1:0]      inc_eff;
  logic                            more;
  logic                            last_in_frame;

  // clamp the increment into 1/32 .. 1
  always_comb begin
    if (phase_inc_i < mlr_pkg::MinInc) begin
      inc_eff = mlr_pkg::MinInc;
    end else if (phase_inc_i > mlr_pkg::PhaseOne) begin
      inc_eff = mlr_pkg::PhaseOne;
    end else begin
      inc_eff = phase_inc_i;
    end
  end

  assign more = (phase_q < mlr_pkg::PhaseOne) && (count_q != mlr_pkg::MaxResults);
  assign last_in_frame = (frame_q == mlr_pkg::FramePosW'(mlr_pkg::FrameLen - 1));

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    frame_d     = frame_q;
    count_d     = count_q;
    have_prev_d = have_prev_q;
    emit_o      = 1'b0;
    cmd_o.load_prod = 1'b0;
    cmd_o.load_cur  = 1'b0;
    cmd_o.commit    = 1'b0;
    cmd_o.phase     = phase_q;
    case (state_q)
      ST_IDLE: begin
        if (stat_i.in_valid) begin
          cmd_o.load_prod = 1'b1;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.load_cur = 1'b1;
        count_d = '0;
        state_d = have_prev_q ? ST_EMIT : ST_COMMIT;
      end
      ST_EMIT: begin
        if (!more) begin
          state_d = ST_COMMIT;
        end else if (stat_i.out_free) begin
          emit_o  = 1'b1;
          phase_d = phase_q + inc_eff;
          count_d = count_q + 1'b1;
          frame_d = last_in_frame ? '0 : frame_q + 1'b1;
        end
      end
      ST_COMMIT: begin
        cmd_o.commit = 1'b1;
        phase_d      = have_prev_q ? (phase_q - mlr_pkg::PhaseOne) : '0;
        have_prev_d  = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign idle_o      = (state_q == ST_IDLE);
  assign frame_end_o = last_in_frame;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= '0;
      frame_q     <= '0;
      count_q     <= '0;
      have_prev_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      frame_q     <= frame_d;
      count_q     <= count_d;
      have_prev_q <= have_prev_d;
    end
  end

endmodule

/* design/mlr_datapath.sv */
// Datapath for the multichannel linear resampler.
// Per-channel lanes: gain multiply, round and saturate, linear interpolation.
// Depends on mlr_pkg.
module mlr_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  mlr_pkg::dp_cmd_t                   cmd_i,
  input  logic signed [mlr_pkg::SampleW-1:0] samples_i [mlr_pkg::NchMax],
  input  logic signed [mlr_pkg::GainW-1:0]   gains_i   [mlr_pkg::NchMax],
  output logic signed [mlr_pkg::AudioW-1:0]  audio_o   [mlr_pkg::NchMax]
);

  localparam int unsigned ProdW = mlr_pkg::SampleW + mlr_pkg::GainW;
  localparam int unsigned RndW  = ProdW - 17;
  localparam int unsigned DiffW = mlr_pkg::AudioW + 1;
  localparam int unsigned IpW   = DiffW + mlr_pkg::PhaseW + 1;

  localparam logic signed [mlr_pkg::AudioW-1:0] Q23Max = 24'sh7FFFFF;
  localparam logic signed [mlr_pkg::AudioW-1:0] Q23Min = 24'sh800000;

  for (genvar c = 0; c < mlr_pkg::NchMax; c++) begin : g_lane
    if (c < mlr_pkg::NumChannels) begin : g_used
      logic signed [ProdW-1:0]           prod_q;
      logic signed [ProdW-1:0]           prod_rnd;
      logic signed [RndW-1:0]            scaled;
      logic signed [mlr_pkg::AudioW-1:0] sat;
      logic signed [mlr_pkg::AudioW-1:0] cur_q;
      logic signed [mlr_pkg::AudioW-1:0] prev_q;
      logic signed [DiffW-1:0]           diff;
      logic signed [IpW-1:0]             ip_prod;
      logic signed [IpW-1:0]             ip_rnd;

      // Q16.16 * Q8.24 -> Q1.23, round half up, saturate
      assign prod_rnd = prod_q + ProdW'(65536);
      assign scaled   = RndW'(prod_rnd >>> 17);
      always_comb begin
        if (scaled > RndW'(Q23Max)) begin
          sat = Q23Max;
        end else if (scaled < RndW'(Q23Min)) begin
          sat = Q23Min;
        end else begin
          sat = scaled[mlr_pkg::AudioW-1:0];
        end
      end

      // prev + floor((cur - prev) * phase / 2^16 + 1/2)
      assign diff    = DiffW'(cur_q) - DiffW'(prev_q);
      assign ip_prod = diff * $signed({1'b0, cmd_i.phase});
      assign ip_rnd  = ip_prod + IpW'(32768);
      assign audio_o[c] = prev_q + ip_rnd[mlr_pkg::AudioW+15:16];

      always_ff @(posedge clk_i) begin
        if (cmd_i.load_prod) begin
          prod_q <= samples_i[c] * gains_i[c];
        end
        if (cmd_i.load_cur) begin
          cur_q <= sat;
        end
      end

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          prev_q <= '0;
        end else if (cmd_i.commit) begin
          prev_q <= cur_q;
        end
      end
    end else begin : g_unused
      assign audio_o[c] = '0;
    end
  end

endmodule

/* design/multichannel_linear_resampler.sv */
// Top level of the multichannel linear resampler.
// Configuration registers, input/output handshake and output word register.
// Depends on mlr_pkg, mlr_ctrl and mlr_datapath.
//
//   Input (in_valid_i / in_stall_o / in_word_i): one word is one simulator step
//   of eight Q16.16 values. Output (out_valid_o / out_stall_i / out_word_o): one
//   word is one Q1.23 audio sample per channel plus frame_end, every 64th word.
//   Configuration (cfg_valid_i / cfg_ready_o): index 0 is the phase increment,
//   1..4 the gain pairs; drop other indexes. Write only while idle.
//   Timing: the gain products load at the edge that accepts a step and the
//   next cycle rounds and saturates them. Then one interpolated word goes out
//   per cycle while the receiver does not stall (0 to 32, set by the phase
//   accumulator against the increment), then the sequencer sees the phase pass
//   the new sample and commits it. The first step after reset emits nothing.
//   The first word of a step enters the output register once the accept and
//   the rounding step are done.
//   Stall: the output register holds its word while out_stall_i is high and the
//   sequencer waits; the next step is accepted once the previous one commits.
//   Reset: gains return to 1.0, increment to 1.0, history and counters clear.
module multichannel_linear_resampler (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  mlr_pkg::in_word_t                   in_word_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output mlr_pkg::out_word_t                  out_word_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [mlr_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [mlr_pkg::CfgDataW-1:0]        cfg_data_i
);

  logic [mlr_pkg::PhaseW-1:0]   phase_inc_q;
  logic [mlr_pkg::CfgDataW-1:0] gain_pair_q [4];

  logic signed [mlr_pkg::SampleW-1:0] samples [mlr_pkg::NchMax];
  logic signed [mlr_pkg::GainW-1:0]   gains   [mlr_pkg::NchMax];
  logic signed [mlr_pkg::AudioW-1:0]  audio   [mlr_pkg::NchMax];

  mlr_pkg::dp_cmd_t   cmd;
  mlr_pkg::ctrl_stat_t stat;
  logic               idle;
  logic               emit;
  logic               frame_end;

  logic               out_valid_q;
  mlr_pkg::out_word_t out_word_q;

  // configuration writes
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_inc_q <= mlr_pkg::PhaseIncReset;
      for (int i = 0; i < 4; i++) begin
        gain_pair_q[i] <= mlr_pkg::GainPairReset;
      end
    end else if (cfg_valid_i) begin
      case (mlr_pkg::cfg_idx_e'(cfg_index_i))
        mlr_pkg::CFG_PHASE_INC: phase_inc_q    <= cfg_data_i[mlr_pkg::PhaseW-1:0];
        mlr_pkg::CFG_GAIN_A:    gain_pair_q[0] <= cfg_data_i;
        mlr_pkg::CFG_GAIN_B:    gain_pair_q[1] <= cfg_data_i;
        mlr_pkg::CFG_GAIN_C:    gain_pair_q[2] <= cfg_data_i;
        mlr_pkg::CFG_GAIN_D:    gain_pair_q[3] <= cfg_data_i;
        default: begin
          // unknown index: drop the write
        end
      endcase
    end
  end

  // unpack words into channel lanes; low half of each pair is the odd channel
  assign samples[0] = in_word_i.sample_ch1;
  assign samples[1] = in_word_i.sample_ch2;
  assign samples[2] = in_word_i.sample_ch3;
  assign samples[3] = in_word_i.sample_ch4;
  assign samples[4] = in_word_i.sample_ch5;
  assign samples[5] = in_word_i.sample_ch6;
  assign samples[6] = in_word_i.sample_ch7;
  assign samples[7] = in_word_i.sample_ch8;

  for (genvar c = 0; c < mlr_pkg::NchMax; c++) begin : g_gain
    assign gains[c] = gain_pair_q[c/2][(c%2)*32 +: 32];
  end

  // handshake and sequencing
  assign in_stall_o    = !idle;
  assign stat.in_valid = in_valid_i;
  assign stat.out_free = !out_valid_q || !out_stall_i;

  mlr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .stat_i      (stat),
    .phase_inc_i (phase_inc_q),
    .cmd_o       (cmd),
    .idle_o      (idle),
    .emit_o      (emit),
    .frame_end_o (frame_end)
  );

  mlr_datapath u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .samples_i (samples),
    .gains_i   (gains),
    .audio_o   (audio)
  );

  // output word register: load on emit, hold while stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_word_q.audio_ch1 <= audio[0];
      out_word_q.audio_ch2 <= audio[1];
      out_word_q.audio_ch3 <= audio[2];
      out_word_q.audio_ch4 <= audio[3];
      out_word_q.audio_ch5 <= audio[4];
      out_word_q.audio_ch6 <= audio[5];
      out_word_q.audio_ch7 <= audio[6];
      out_word_q.audio_ch8 <= audio[7];
      out_word_q.frame_end <= frame_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule
